>>> rtl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// shared constants, codes and types of the counted multiset table
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int ENTRIES    = 32;
    localparam int COUNT_BITS = 16;
    localparam int ELEM_BITS  = 32;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W  = $clog2(ENTRIES + 1);
    // full table of saturated counts stays below 2^(COUNT_BITS + clog2(ENTRIES))
    localparam int TOTAL_W = COUNT_BITS + $clog2(ENTRIES);

    localparam int FUNC_W = 2;
    localparam int IN_W   = 32;
    localparam int RES_W  = 1 + COUNT_BITS + USED_W + TOTAL_W + 1 + 1;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - RES_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // operation codes, code 3 behaves as a query
    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

    typedef logic [ELEM_BITS-1:0]  t_key;
    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;

    // write request into the entry store
    typedef struct packed {
        logic en;
        t_idx addr;
        t_key key;
        t_cnt cnt;
    } t_wr;

endpackage

>>> rtl/cmt_store.sv
// ----------------------------------------------------------------------------
// cmt_store
// entry memory: key and count per slot, one write and one registered read
// ----------------------------------------------------------------------------
module cmt_store (
    input  logic           i_clk,
    input  cmt_pkg::t_wr   i_wr,
    input  cmt_pkg::t_idx  i_rd_addr,
    output cmt_pkg::t_key  o_rd_key,
    output cmt_pkg::t_cnt  o_rd_cnt
);
    import cmt_pkg::*;

    t_key r_keys [ENTRIES];
    t_cnt r_counts [ENTRIES];
    t_key r_rd_key;
    t_cnt r_rd_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_keys[i_wr.addr]   <= i_wr.key;
            r_counts[i_wr.addr] <= i_wr.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= r_keys[i_rd_addr];
        r_rd_cnt <= r_counts[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_cnt = r_rd_cnt;

endmodule

>>> rtl/counted_multiset_table.sv
// ----------------------------------------------------------------------------
// counted_multiset_table
// Frequency table of up to ENTRIES distinct elements with a count for each.
// Every item on the slave side carries an operation in tuser (add, remove,
// query; code 3 acts as a query) and an element in tdata, and yields exactly
// one result item. The block handles one item at a time: it takes an item
// only while its sequencer is idle, then walks the entry memory one slot per
// cycle through a single key comparator until it finds the element or runs
// past the last held entry. When a remove frees a slot, the last entry is
// moved into it before the result is handed on. A stalled result side holds
// the sequencer in its done state while the output register stays full. A
// finished result waits in the output register while the next item is
// already taken. Adds of a new element into a full table are refused and
// flagged; counts saturate at their maximum.
// ----------------------------------------------------------------------------
module counted_multiset_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [cmt_pkg::IN_W-1:0]        i_s_tdata,   // [31:0] elem
    input  logic [cmt_pkg::FUNC_W-1:0]      i_s_tuser,   // [1:0] func
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cmt_pkg::OUT_W-1:0]       o_m_tdata    // found, count[16],
                                                         // distinct[6], total[21],
                                                         // rejected, empty_res,
                                                         // zero pad
);
    import cmt_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;   // waiting for an item
    localparam logic [2:0] ST_SCAN = 3'd1;   // compare one slot per cycle
    localparam logic [2:0] ST_EXEC = 3'd2;   // apply the operation
    localparam logic [2:0] ST_MOVE = 3'd3;   // fill the freed slot with the last entry
    localparam logic [2:0] ST_DONE = 3'd4;   // hand the result to the output register

    logic [2:0]          r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    t_key                r_key, n_key;
    t_idx                r_idx, n_idx;
    logic                r_hit, n_hit;
    t_idx                r_slot, n_slot;
    t_cnt                r_cnt, n_cnt;
    logic                r_rej, n_rej;
    logic [USED_W-1:0]   r_used, n_used;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_data, n_out_data;

    t_wr                 wr;
    t_idx                rd_addr;
    t_key                rd_key;
    t_cnt                rd_cnt;
    logic                key_eq;
    logic                scan_last;
    logic [USED_W-1:0]   used_m1;

    cmt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_cnt  (rd_cnt)
    );

    // the one shared comparator of the scan
    assign key_eq    = (rd_key == r_key);
    assign scan_last = ((USED_W'(r_idx) + USED_W'(1)) == r_used);
    assign used_m1   = r_used - USED_W'(1);

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_rej       = r_rej;
        n_used      = r_used;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rd_addr     = r_idx;
        wr          = '0;

        // result taken downstream
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (i_s_tvalid) begin
                    n_func = i_s_tuser;
                    n_key  = i_s_tdata[ELEM_BITS-1:0];
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_slot = '0;
                    n_cnt  = '0;
                    n_rej  = 1'b0;
                    // empty table: nothing to scan
                    n_state = (r_used == '0) ? ST_EXEC : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (key_eq) begin
                    n_hit   = 1'b1;
                    n_slot  = r_idx;
                    n_cnt   = rd_cnt;
                    n_state = ST_EXEC;
                end else if (scan_last) begin
                    n_state = ST_EXEC;
                end else begin
                    rd_addr = r_idx + t_idx'(1);
                    n_idx   = r_idx + t_idx'(1);
                end
            end
            ST_EXEC: begin
                n_state  = ST_DONE;
                wr.key   = r_key;
                wr.addr  = r_slot;
                if (r_func == FN_ADD) begin
                    if (r_hit) begin
                        if (r_cnt != COUNT_MAX) begin
                            wr.en   = 1'b1;
                            wr.cnt  = r_cnt + t_cnt'(1);
                            n_cnt   = r_cnt + t_cnt'(1);
                            n_total = r_total + TOTAL_W'(1);
                        end
                    end else if (r_used < USED_W'(ENTRIES)) begin
                        // append a new entry behind the last one
                        wr.en   = 1'b1;
                        wr.addr = r_used[IDX_W-1:0];
                        wr.cnt  = t_cnt'(1);
                        n_cnt   = t_cnt'(1);
                        n_used  = r_used + USED_W'(1);
                        n_total = r_total + TOTAL_W'(1);
                    end else begin
                        n_rej = 1'b1;
                    end
                end else if (r_func == FN_REMOVE && r_hit) begin
                    if (r_cnt > t_cnt'(1)) begin
                        wr.en   = 1'b1;
                        wr.cnt  = r_cnt - t_cnt'(1);
                        n_cnt   = r_cnt - t_cnt'(1);
                        n_total = r_total - TOTAL_W'(1);
                    end else begin
                        // slot freed: fetch the last entry to move into it
                        n_total = r_total - TOTAL_W'(r_cnt);
                        n_used  = used_m1;
                        n_cnt   = '0;
                        rd_addr = used_m1[IDX_W-1:0];
                        n_state = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                wr.en   = 1'b1;
                wr.addr = r_slot;
                wr.key  = rd_key;
                wr.cnt  = rd_cnt;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD{1'b0}}, (r_used == '0), r_rej,
                                   r_total, r_used, r_cnt, r_hit};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
        r_rej      <= n_rej;
        r_out_data <= n_out_data;
    end

    // entry count stays within capacity
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(ENTRIES))
        else $error("entry count beyond capacity");

    // every held entry has a nonzero count, so the total is zero only when empty
    a_total_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) == (r_total == '0))
        else $error("total and entry count disagree");

    // a refused add reports no hit and no count
    a_rej_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[RES_W-2] |->
            !r_out_data[0] && (r_out_data[COUNT_BITS:1] == '0))
        else $error("refused add with hit or count");

    // an accepted item leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_state != ST_IDLE)
        else $error("item accepted but sequencer idle");

    // a result is only loaded when the output register is free or drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready && r_state == ST_DONE |=> r_state == ST_DONE)
        else $error("result overwrote a pending item");

endmodule

>>> tb/cmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_checker
// Watches both stream channels of the counted multiset table, keeps its own
// copy of the entry table, predicts one result per accepted item and compares
// every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cmt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [cmt_pkg::IN_W-1:0]     i_s_tdata,    // [31:0] elem
    input  logic [cmt_pkg::FUNC_W-1:0]   i_s_tuser,    // [1:0] func
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [cmt_pkg::OUT_W-1:0]    i_m_tdata,    // found, count, distinct,
                                                       // total, rejected,
                                                       // empty_res, zero pad
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_refused,
    output int                           o_freed
);
    import cmt_pkg::*;

    localparam int MAX_REPORTS = 10;

    // same layout as the result bits, found in bit 0
    typedef struct packed {
        logic               empty_res;
        logic               rejected;
        logic [TOTAL_W-1:0] total;
        logic [USED_W-1:0]  distinct;
        t_cnt               count;
        logic               found;
    } t_table_result;

    t_key               held_keys [ENTRIES];
    t_cnt               held_cnts [ENTRIES];
    logic [USED_W-1:0]  held_used;
    logic [TOTAL_W-1:0] held_total;

    t_table_result      result_q[$];
    t_table_result      want;
    t_table_result      got;
    logic [OUT_PAD-1:0] got_pad;
    int                 fails = 0;
    int                 checked = 0;
    int                 refused = 0;
    int                 freed = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_refused    = 0;
        o_freed      = 0;
    end

    // applies one operation to the shadow table and returns its result
    function automatic t_table_result apply_op(logic [FUNC_W-1:0] fn, t_key key);
        t_table_result     r;
        int                slot;
        t_cnt              c;
        logic [USED_W-1:0] last;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && i < held_used && held_keys[i] == key) slot = i;
        end
        c = (slot >= 0) ? held_cnts[slot] : '0;
        r = '0;
        r.found = (slot >= 0);
        if (fn == FN_ADD) begin
            if (slot >= 0) begin
                // saturated counts stay where they are
                if (c != COUNT_MAX) begin
                    c = c + 1'b1;
                    held_cnts[slot] = c;
                    held_total = held_total + 1'b1;
                end
            end else if (held_used < ENTRIES) begin
                held_keys[held_used[IDX_W-1:0]] = key;
                held_cnts[held_used[IDX_W-1:0]] = t_cnt'(1);
                held_used = held_used + 1'b1;
                held_total = held_total + 1'b1;
                c = t_cnt'(1);
            end else begin
                r.rejected = 1'b1;
                refused++;
            end
        end else if (fn == FN_REMOVE && slot >= 0) begin
            if (c > 1) begin
                c = c - 1'b1;
                held_cnts[slot] = c;
                held_total = held_total - 1'b1;
            end else begin
                // last entry moves into the freed slot
                last = held_used - 1'b1;
                held_total = held_total - c;
                held_keys[slot] = held_keys[last[IDX_W-1:0]];
                held_cnts[slot] = held_cnts[last[IDX_W-1:0]];
                held_used = last;
                c = '0;
                freed++;
            end
        end
        r.count     = c;
        r.distinct  = held_used;
        r.total     = held_total;
        r.empty_res = (held_used == 0);
        return r;
    endfunction

    function automatic string fmt_result(t_table_result r);
        return $sformatf("found=%0d count=%0d distinct=%0d total=%0d rejected=%0d empty=%0d",
                         r.found, r.count, r.distinct, r.total, r.rejected, r.empty_res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_used  = '0;
            held_total = '0;
            result_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) result_q.push_back(apply_op(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got     = i_m_tdata[RES_W-1:0];
                got_pad = i_m_tdata[OUT_W-1:RES_W];
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%t unexpected result item: %s", $realtime, fmt_result(got));
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    if (got.found !== want.found || got.count !== want.count ||
                        got.distinct !== want.distinct || got.total !== want.total ||
                        got.rejected !== want.rejected || got.empty_res !== want.empty_res ||
                        got_pad !== '0) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("%t mismatch on result %0d", $realtime, checked);
                            $display("    expected %s pad=0", fmt_result(want));
                            $display("    actual   %s pad=%0h", fmt_result(got), got_pad);
                        end
                    end
                end
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_refused    <= refused;
        o_freed      <= freed;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the counted multiset table: a directed run over
// element extremes and every operation, then random fill and drain rounds over
// a pool of elements larger than the table, with bursty input and a stalling
// result side.
// ----------------------------------------------------------------------------
module tb_top;
    import cmt_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;   // unused code, acts as query
    localparam int   POOL_SIZE  = 48;                 // more elements than slots
    localparam int   ROUNDS     = 4;
    localparam int   FILL_ITEMS = 90;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;       // [31:0] elem
    logic [FUNC_W-1:0] s_tuser = '0;       // [1:0] func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;            // found, count, distinct, total,
                                           // rejected, empty_res, zero pad

    int fail_count;
    int pending;
    int checked;
    int refused;
    int freed;

    // sender burst state and receiver stall pattern state
    int   burst_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;
    int   items_sent = 0;

    // element pool and how often each one should be held right now
    t_key pool [POOL_SIZE];
    int   pool_tally [POOL_SIZE];
    int   live_count = 0;

    counted_multiset_table uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    cmt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_refused    (refused),
        .o_freed      (freed)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // result side: switches between random stall modes
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;                              // no stalls
            1: m_tready <= 1'($urandom_range(0, 1));          // coin flip
            2: m_tready <= ($urandom_range(0, 4) == 0);       // mostly stalled
            default: m_tready <= rx_left[3];                  // long on/off stretches
        endcase
    end

    // offers one item, idling first when a burst has run out
    task automatic send_item(input logic [FUNC_W-1:0] fn, input t_key el);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= el;
        s_tuser  <= fn;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // operation on a pool element, keeping its expected holding in step
    task automatic pool_op(input logic [FUNC_W-1:0] fn, input int idx);
        if (fn == FN_ADD) begin
            if (pool_tally[idx] > 0) begin
                pool_tally[idx]++;
            end else if (live_count < ENTRIES) begin
                pool_tally[idx] = 1;
                live_count++;
            end
        end else if (fn == FN_REMOVE && pool_tally[idx] > 0) begin
            pool_tally[idx]--;
            if (pool_tally[idx] == 0) live_count--;
        end
        send_item(fn, pool[idx]);
    endtask

    // queries and removes of random elements that are almost surely absent
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)      send_item(FN_REMOVE, $urandom);
        else if (pick == 1) send_item(FN_QUERY, $urandom);
        else                send_item(FN_SPARE, $urandom);
    endtask

    initial begin
        int   pick;
        int   idx;
        int   waited;
        logic dup;

        // pool: the element extremes plus distinct random values
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) begin
            do begin
                pool[i] = $urandom;
                dup = 1'b0;
                for (int j = 0; j < i; j++) if (pool[j] == pool[i]) dup = 1'b1;
            end while (dup);
        end
        for (int i = 0; i < POOL_SIZE; i++) pool_tally[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, hits, spare code, slot moves
        send_item(FN_QUERY,  32'h0000_0000);   // query on empty table
        send_item(FN_REMOVE, 32'h8000_0000);   // remove on empty table
        send_item(FN_ADD,    32'h8000_0000);
        send_item(FN_ADD,    32'h7FFF_FFFF);
        send_item(FN_ADD,    32'hFFFF_FFFF);
        send_item(FN_ADD,    32'h0000_0000);
        send_item(FN_ADD,    32'hFFFF_FFFF);   // existing element, count 2
        send_item(FN_SPARE,  32'hFFFF_FFFF);   // unused code on a held element
        send_item(FN_QUERY,  32'h7FFF_FFFF);
        send_item(FN_QUERY,  32'h1234_5678);   // absent query
        send_item(FN_REMOVE, 32'h8000_0000);   // frees slot 0, last entry moves in
        send_item(FN_QUERY,  32'h0000_0000);   // moved entry still found
        send_item(FN_REMOVE, 32'hFFFF_FFFF);   // 2 -> 1
        send_item(FN_REMOVE, 32'hFFFF_FFFF);   // 1 -> 0, entry freed
        send_item(FN_REMOVE, 32'hFFFF_FFFF);   // absent remove
        send_item(FN_SPARE,  32'h5555_5555);   // unused code on an absent element
        send_item(FN_REMOVE, 32'h0000_0000);
        send_item(FN_REMOVE, 32'h7FFF_FFFF);   // table empty again
        send_item(FN_ADD,    32'hAAAA_AAAA);
        send_item(FN_REMOVE, 32'hAAAA_AAAA);   // sole entry freed

        // random rounds: fill well past capacity, then drain to empty
        for (int r = 0; r < ROUNDS; r++) begin
            repeat (FILL_ITEMS) begin
                pick = $urandom_range(0, 99);
                idx  = $urandom_range(0, POOL_SIZE - 1);
                if (pick < 70)      pool_op(FN_ADD, idx);
                else if (pick < 85) pool_op(FN_REMOVE, idx);
                else if (pick < 91) pool_op(FN_QUERY, idx);
                else if (pick < 94) pool_op(FN_SPARE, idx);
                else                send_noise();
            end
            while (live_count > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    do idx = $urandom_range(0, POOL_SIZE - 1); while (pool_tally[idx] == 0);
                    pool_op(FN_REMOVE, idx);
                end
            end
        end
        s_tvalid <= 1'b0;

        // let the last results drain, then wait on for stray output
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("sent %0d items over directed cases and fill/drain rounds; %0d results checked",
                 items_sent, checked);
        $display("%0d adds refused on a full table, %0d entries freed by removal",
                 refused, freed);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #40ms;
        $display("timeout, %0d results still outstanding", pending);
        $display("FAIL");
        $finish;
    end

endmodule
